// ===== src/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, constants and the per-byte CRC-16/ARC update of the frame
// parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [3:0]  MAX_PAYLOAD = 4'd8;
    localparam int          STORE_DEPTH = 8;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  HDR_FIRST   = 8'hAA;
    localparam logic [7:0]  HDR_SECOND  = 8'h55;

    typedef enum logic [2:0] {
        PH_HDR1   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_LO = 3'd5,
        PH_CRC_HI = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [3:0]  payload_len;
        logic [63:0] payload_bytes;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] v);
        logic [15:0] c;
        c = acc ^ {8'h00, v};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/sfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfp_stream_if
// Valid/ready channels of the frame parser: received bytes in, frames out.
// ----------------------------------------------------------------------------
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_type;
    logic [3:0]  payload_len;
    logic [63:0] payload_bytes;

    modport source (output valid, output frame_type, output payload_len,
                    output payload_bytes, input ready);
    modport sink   (input valid, input frame_type, input payload_len,
                    input payload_bytes, output ready);
endinterface

// ===== src/sfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfp_in_stage
// Input register: holds one received word until the parser consumes it.
// ----------------------------------------------------------------------------
module sfp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_accept;

    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;
    assign n_valid  = w_accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== src/sfp_parser.sv =====
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine: header hunt, type, length, payload capture, running
// CRC-16/ARC and check compare, one word per consume.
// ----------------------------------------------------------------------------
module sfp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic [7:0]      i_byte,
    output logic            o_res_valid,
    output sfp_pkg::t_result o_result
);

    sfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [3:0]  r_len, n_len;
    logic [3:0]  r_wi, n_wi;
    logic [7:0]  r_store [sfp_pkg::STORE_DEPTH];
    logic [7:0]  n_store [sfp_pkg::STORE_DEPTH];
    logic [7:0]  r_chk_lo, n_chk_lo;
    logic [15:0] r_crc, n_crc;
    logic [63:0] w_packed;

    always_comb begin
        for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
            w_packed[8*k +: 8] = (4'(k) < r_len) ? r_store[k] : 8'h00;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_wi        = r_wi;
        n_store     = r_store;
        n_chk_lo    = r_chk_lo;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        unique case (r_phase)
            sfp_pkg::PH_HDR1: begin
                if (i_byte == sfp_pkg::HDR_FIRST) begin
                    n_phase = sfp_pkg::PH_HDR2;
                end
            end
            sfp_pkg::PH_HDR2: begin
                if (i_byte == sfp_pkg::HDR_SECOND) begin
                    n_phase = sfp_pkg::PH_TYPE;
                end else if (i_byte == sfp_pkg::HDR_FIRST) begin
                    n_phase = sfp_pkg::PH_HDR2;
                end else begin
                    n_phase = sfp_pkg::PH_HDR1;
                end
            end
            sfp_pkg::PH_TYPE: begin
                n_type = i_byte;
                for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
                    n_store[k] = 8'h00;
                end
                n_crc   = sfp_pkg::crc_step(16'h0000, i_byte);
                n_phase = sfp_pkg::PH_LEN;
            end
            sfp_pkg::PH_LEN: begin
                n_wi = 4'd0;
                if (i_byte > {4'd0, sfp_pkg::MAX_PAYLOAD}) begin
                    n_len   = i_byte[3:0];
                    n_phase = sfp_pkg::PH_HDR1;
                end else begin
                    n_len   = i_byte[3:0];
                    n_crc   = sfp_pkg::crc_step(r_crc, i_byte);
                    n_phase = (i_byte != 8'd0) ? sfp_pkg::PH_DATA : sfp_pkg::PH_CRC_LO;
                end
            end
            sfp_pkg::PH_DATA: begin
                if (r_wi < sfp_pkg::MAX_PAYLOAD) begin
                    n_store[r_wi[2:0]] = i_byte;
                    n_crc              = sfp_pkg::crc_step(r_crc, i_byte);
                end
                n_wi = r_wi + 4'd1;
                if (n_wi >= r_len) begin
                    n_phase = sfp_pkg::PH_CRC_LO;
                end
            end
            sfp_pkg::PH_CRC_LO: begin
                n_chk_lo = i_byte;
                n_phase  = sfp_pkg::PH_CRC_HI;
            end
            default: begin
                // crc high byte, also the unused phase code
                n_phase = sfp_pkg::PH_HDR1;
                if ({i_byte, r_chk_lo} == r_crc) begin
                    o_res_valid = 1'b1;
                end
            end
        endcase
    end

    assign o_result.frame_type    = r_type;
    assign o_result.payload_len   = r_len;
    assign o_result.payload_bytes = w_packed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfp_pkg::PH_HDR1;
            r_type   <= 8'h00;
            r_len    <= 4'd0;
            r_wi     <= 4'd0;
            r_chk_lo <= 8'h00;
            r_crc    <= 16'h0000;
            for (int k = 0; k < sfp_pkg::STORE_DEPTH; k++) begin
                r_store[k] <= 8'h00;
            end
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_len    <= n_len;
            r_wi     <= n_wi;
            r_chk_lo <= n_chk_lo;
            r_crc    <= n_crc;
            r_store  <= n_store;
        end
    end

endmodule

// ===== src/sfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfp_out_stage
// Result register: holds an accepted frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sfp_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_can_take,
    output logic             o_valid,
    output sfp_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    sfp_pkg::t_result r_result;

    assign o_can_take = !r_valid || i_ready;
    assign n_valid    = (r_valid && !i_ready) || i_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/sync_frame_parser_crc16.sv =====
// ----------------------------------------------------------------------------
// sync_frame_parser_crc16
// Byte-serial receiver for frames AA 55 TYPE LEN DATA[LEN] CRC_L CRC_H with a
// CRC-16/ARC check over TYPE, LEN and DATA; good frames come out as one word.
//
//   channel  dir  word contents                                 handshake
//   i_in     in   rx_byte[7:0]                                  valid/ready
//   o_out    out  frame_type[7:0] payload_len[3:0]               valid/ready
//                 payload_bytes[63:0]
//
// one received byte per cycle while the result register is free or being taken;
// the parser state machine and its CRC byte update take one byte per consume
// a frame is loaded into the result register when its last byte leaves the input register
// synchronous active-low reset returns to header hunt; no clearing pass
// a stalled output holds its word, one more byte waits in the input register
// ----------------------------------------------------------------------------
module sync_frame_parser_crc16 (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sfp_in_if.sink   i_in,
    sfp_out_if.source o_out
);

    logic             w_in_valid;
    logic [7:0]       w_in_byte;
    logic             w_can_take;
    logic             w_advance;
    logic             w_res_valid;
    sfp_pkg::t_result w_result;
    sfp_pkg::t_result w_out_result;

    assign w_advance = w_in_valid && w_can_take;

    sfp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_byte    (i_in.rx_byte),
        .o_ready   (i_in.ready),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    sfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    sfp_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_res_valid),
        .i_result   (w_result),
        .i_ready    (o_out.ready),
        .o_can_take (w_can_take),
        .o_valid    (o_out.valid),
        .o_result   (w_out_result)
    );

    assign o_out.frame_type    = w_out_result.frame_type;
    assign o_out.payload_len   = w_out_result.payload_len;
    assign o_out.payload_bytes = w_out_result.payload_bytes;

endmodule

// ===== src/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_out_len,
    input logic [63:0] i_out_bytes
);

    // stalled result word stays valid and holds its length and bytes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_len)
            && $stable(i_out_bytes)))
        else $error("stalled result word changed");

    // empty output side never blocks the input side
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with output empty");

    // with both stages full, input readiness follows the output side
    a_in_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && !i_in_ready) |=> (i_in_ready == i_out_ready))
        else $error("input readiness does not track output stall");

    // length in range and bytes at or above it are zero
    a_len_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_len <= 4'd8)
            && ((i_out_len == 4'd8) || ((i_out_bytes >> {i_out_len, 3'b000}) == 64'd0))))
        else $error("bad length or nonzero padding");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sync_frame_parser_crc16 sfp_checker u_sfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_len   (o_out.payload_len),
    .i_out_bytes (o_out.payload_bytes)
);
